// ===== rtl/moc_sfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moc_sfa_pkg
// Types, request codes and fixed-point constants of the segment flux
// attenuation block.
// ----------------------------------------------------------------------------
package moc_sfa_pkg;

  localparam int unsigned DefMaxRegions  = 256;
  localparam int unsigned DefMaxGroups   = 16;
  localparam int unsigned DefMaxPolar    = 4;
  localparam int unsigned DefExpTableSize = 1024;

  localparam int unsigned NumPolarRegs = 4;
  localparam int unsigned InvSinW      = 22;

  // optical length range of the table, Q16.16 (10.0)
  localparam logic [37:0] TAU_RANGE_Q16 = 38'd655360;
  localparam logic [16:0] ONE_Q16       = 17'd65536;
  localparam logic [63:0] EXP_M1_Q32    = 64'd1580030169;
  // floor(x / 10) = (x * RECIP10) >> 35 for any x below 2^32
  localparam logic [31:0] RECIP10       = 32'hCCCCCCCD;
  localparam int unsigned Recip10Shift  = 35;
  localparam logic [21:0] INV_SIN_RESET = 22'd65536;

  localparam logic [1:0] REQ_SWEEP = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [7:0]         region;
    logic [3:0]         group;
    logic [1:0]         polar;
    logic signed [31:0] angular_flux;
    logic signed [31:0] reduced_source;
    logic [23:0]        sigma_t;
    logic [23:0]        seg_length;
    logic [23:0]        polar_weight;
    logic signed [31:0] flux_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_angular_flux;
    logic signed [31:0] scalar_flux_value;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic mem_rd;
    logic step_mul;
    logic step_tau;
    logic step_div;
    logic step_pos;
    logic step_addr;
    logic step_rom;
    logic step_interp;
    logic step_delta;
    logic step_contrib;
    logic step_update;
    logic write_req;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic       clear_last;
    logic [1:0] req;
    logic       idx_ok;
    logic       polar_ok;
    logic       out_free;
  } status_t;

endpackage

// ===== rtl/moc_sfa_atten_rom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moc_sfa_atten_rom
// Attenuation table 1 - exp(-tau), built at elaboration, two registered
// read ports for the two interpolation points.
// ----------------------------------------------------------------------------
module moc_sfa_atten_rom #(
  parameter int unsigned EXP_TABLE_SIZE = 1024,
  parameter int unsigned TW = $clog2(EXP_TABLE_SIZE + 1)
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [TW-1:0] addr_lo_i,
  input  logic [TW-1:0] addr_hi_i,
  output logic [16:0]   lo_o,
  output logic [16:0]   hi_o
);
  import moc_sfa_pkg::*;

  typedef logic [16:0] rom_arr_t [EXP_TABLE_SIZE+1];

  function automatic logic [63:0] div_small(input logic [63:0] t, input int n);
    logic [63:0] r;
    case (n)
      1:  r = t;
      2:  r = t / 2;
      3:  r = t / 3;
      4:  r = t / 4;
      5:  r = t / 5;
      6:  r = t / 6;
      7:  r = t / 7;
      8:  r = t / 8;
      9:  r = t / 9;
      10: r = t / 10;
      11: r = t / 11;
      12: r = t / 12;
      13: r = t / 13;
      14: r = t / 14;
      15: r = t / 15;
      16: r = t / 16;
      17: r = t / 17;
      18: r = t / 18;
      19: r = t / 19;
      20: r = t / 20;
      21: r = t / 21;
      22: r = t / 22;
      23: r = t / 23;
      24: r = t / 24;
      default: r = t;
    endcase
    return r;
  endfunction

  // exp(-x) in Q32 with x in Q32, truncated series on the fraction
  function automatic logic [63:0] exp_neg_q32(input logic [63:0] x);
    logic [63:0] whole;
    logic [63:0] f;
    logic [63:0] term;
    logic signed [64:0] sum;
    logic [63:0] v;
    whole = x >> 32;
    f     = {32'd0, x[31:0]};
    term  = 64'd1 << 32;
    sum   = 65'sd4294967296;
    for (int n = 1; n <= 24; n++) begin
      term = div_small((term * f) >> 32, n);
      if (n % 2 == 1) sum = sum - $signed({1'b0, term});
      else sum = sum + $signed({1'b0, term});
    end
    if (sum < 0) sum = '0;
    v = sum[63:0];
    for (int k = 0; k < 16; k++) begin
      if (64'(k) < whole && v != 64'd0) v = (v * EXP_M1_Q32) >> 32;
    end
    return v;
  endfunction

  function automatic rom_arr_t build_rom();
    rom_arr_t    t;
    logic [63:0] xq;
    logic [63:0] e16;
    for (int i = 0; i <= EXP_TABLE_SIZE; i++) begin
      xq  = ((64'(i) * 64'(TAU_RANGE_Q16)) << 16) / EXP_TABLE_SIZE;
      e16 = (exp_neg_q32(xq) + 64'h8000) >> 16;
      if (e16 > 64'(ONE_Q16)) e16 = 64'(ONE_Q16);
      t[i] = 17'(64'(ONE_Q16) - e16);
    end
    return t;
  endfunction

  localparam rom_arr_t AttenRom = build_rom();

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      lo_o <= AttenRom[addr_lo_i];
      hi_o <= AttenRom[addr_hi_i];
    end
  end

endmodule

// ===== rtl/moc_sfa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moc_sfa_ctrl
// Sequencer: clearing pass after reset, then one item at a time through the
// datapath steps.
// ----------------------------------------------------------------------------
module moc_sfa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  moc_sfa_pkg::status_t status_i,
  output moc_sfa_pkg::cmd_t    cmd_o
);
  import moc_sfa_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_MUL, ST_TAU, ST_DIV, ST_POS, ST_ADDR,
    ST_ROM, ST_INTERP, ST_DELTA, ST_CONTRIB, ST_UPDATE, ST_RD, ST_WR, ST_DONE
  } state_e;

  state_e state_q;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_CLEAR:   cmd_o.clear        = 1'b1;
      ST_IDLE:    cmd_o.load         = in_valid_i;
      ST_MUL: begin
        cmd_o.step_mul = 1'b1;
        cmd_o.mem_rd   = 1'b1;
      end
      ST_TAU:     cmd_o.step_tau     = 1'b1;
      ST_DIV:     cmd_o.step_div     = 1'b1;
      ST_POS:     cmd_o.step_pos     = 1'b1;
      ST_ADDR:    cmd_o.step_addr    = 1'b1;
      ST_ROM:     cmd_o.step_rom     = 1'b1;
      ST_INTERP:  cmd_o.step_interp  = 1'b1;
      ST_DELTA:   cmd_o.step_delta   = 1'b1;
      ST_CONTRIB: cmd_o.step_contrib = 1'b1;
      ST_UPDATE:  cmd_o.step_update  = 1'b1;
      ST_RD:      cmd_o.mem_rd       = 1'b1;
      ST_WR:      cmd_o.write_req    = 1'b1;
      ST_DONE:    cmd_o.finish       = status_i.out_free;
      default:    cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      case (state_q)
        ST_CLEAR: if (status_i.clear_last) state_q <= ST_IDLE;
        ST_IDLE:  if (in_valid_i) state_q <= ST_DECODE;
        ST_DECODE: begin
          if (status_i.req == REQ_SWEEP && status_i.idx_ok && status_i.polar_ok) begin
            state_q <= ST_MUL;
          end else if (status_i.req == REQ_READ && status_i.idx_ok) begin
            state_q <= ST_RD;
          end else if (status_i.req == REQ_WRITE && status_i.idx_ok) begin
            state_q <= ST_WR;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_MUL:     state_q <= ST_TAU;
        ST_TAU:     state_q <= ST_DIV;
        ST_DIV:     state_q <= ST_POS;
        ST_POS:     state_q <= ST_ADDR;
        ST_ADDR:    state_q <= ST_ROM;
        ST_ROM:     state_q <= ST_INTERP;
        ST_INTERP:  state_q <= ST_DELTA;
        ST_DELTA:   state_q <= ST_CONTRIB;
        ST_CONTRIB: state_q <= ST_UPDATE;
        ST_UPDATE:  state_q <= ST_DONE;
        ST_RD:      state_q <= ST_DONE;
        ST_WR:      state_q <= ST_DONE;
        ST_DONE:    if (status_i.out_free) state_q <= ST_IDLE;
        default:    state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/moc_sfa_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moc_sfa_datapath
// Item register, polar registers, optical length and attenuation arithmetic,
// scalar flux store and output register.
// ----------------------------------------------------------------------------
module moc_sfa_datapath #(
  parameter int unsigned MAX_REGIONS    = moc_sfa_pkg::DefMaxRegions,
  parameter int unsigned MAX_GROUPS     = moc_sfa_pkg::DefMaxGroups,
  parameter int unsigned MAX_POLAR      = moc_sfa_pkg::DefMaxPolar,
  parameter int unsigned EXP_TABLE_SIZE = moc_sfa_pkg::DefExpTableSize
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  moc_sfa_pkg::in_item_t  in_item_i,
  input  logic                   cfg_valid_i,
  input  logic [1:0]             cfg_index_i,
  input  logic [21:0]            cfg_data_i,
  input  moc_sfa_pkg::cmd_t      cmd_i,
  output moc_sfa_pkg::status_t   status_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output moc_sfa_pkg::out_item_t out_item_o
);
  import moc_sfa_pkg::*;

  localparam int unsigned Depth = MAX_REGIONS * MAX_GROUPS;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned TW = $clog2(EXP_TABLE_SIZE + 1);
  localparam int unsigned KW = (EXP_TABLE_SIZE > 1) ? $clog2(EXP_TABLE_SIZE) : 1;
  localparam int unsigned PW = KW + 16;

  in_item_t    item_q;
  logic [21:0] inv_sin_q [NumPolarRegs];
  logic [AW-1:0] clr_cnt_q;

  logic signed [31:0] mem [Depth];
  logic signed [31:0] rdata_q;

  logic [47:0]        prod_q;
  logic signed [32:0] diff_q;
  logic [37:0]        tau_q;
  logic               big_q;
  logic [15:0]        q10_q;
  logic [47:0]        qs_q;
  logic [17:0]        y_q;
  logic [PW-1:0]      pos_q;
  logic [16:0]        lo, hi;
  logic [16:0]        att_q;
  logic signed [34:0] delta_q;
  logic signed [43:0] contrib_q;
  logic signed [31:0] psi_sat_q, sum_sat_q;
  logic               sat_psi_q, sat_sum_q;
  logic               out_valid_q;
  out_item_t          out_q;
  out_item_t          result;

  logic          idx_ok, polar_ok;
  logic [AW-1:0] idx;
  logic [31:0]   idx_full;

  // arithmetic between steps
  logic [53:0]        tau_prod;
  logic [51:0]        q10_prod;
  logic [3:0]         rem10;
  logic [19:0]        rem_full;
  logic [49:0]        yq_prod;
  logic [47:0]        pos_full;
  logic [16:0]        hi_c, dif;
  logic [32:0]        dif_prod;
  logic [17:0]        att_sum;
  logic signed [50:0] delta_prod;
  logic signed [59:0] contrib_prod;
  logic signed [35:0] psi_diff;
  logic signed [44:0] sum_full;
  logic signed [31:0] psi_sat, sum_sat;
  logic               psi_ovf, sum_ovf;
  logic [TW-1:0]      addr_lo, addr_hi;

  assign idx_ok   = (32'(item_q.region) < MAX_REGIONS) && (32'(item_q.group) < MAX_GROUPS);
  assign polar_ok = 32'(item_q.polar) < MAX_POLAR;
  assign idx_full = 32'(item_q.region) * MAX_GROUPS + 32'(item_q.group);
  assign idx      = idx_full[AW-1:0];

  assign status_o.clear_last = (32'(clr_cnt_q) == Depth - 1);
  assign status_o.req        = item_q.req_type;
  assign status_o.idx_ok     = idx_ok;
  assign status_o.polar_ok   = polar_ok;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NumPolarRegs; p++) inv_sin_q[p] <= INV_SIN_RESET;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) inv_sin_q[cfg_index_i] <= cfg_data_i;
      if (cmd_i.clear) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cmd_i.finish) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // scalar flux store, one write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mem[clr_cnt_q] <= '0;
    end else if (cmd_i.step_update) begin
      mem[idx] <= sum_sat;
    end else if (cmd_i.write_req) begin
      mem[idx] <= item_q.flux_value;
    end
    if (cmd_i.mem_rd) rdata_q <= mem[idx];
  end

  always_comb begin
    tau_prod = {22'd0, prod_q[47:16]} * {32'd0, inv_sin_q[item_q.polar]};
    q10_prod = {32'd0, tau_q[19:0]} * {20'd0, RECIP10};
    rem_full = tau_q[19:0] - 20'(q10_q) * 20'd10;
    rem10    = rem_full[3:0];
    yq_prod  = {32'd0, y_q} * {18'd0, RECIP10};
    pos_full = qs_q + {33'd0, yq_prod[49:Recip10Shift]};
    hi_c     = (hi < lo) ? lo : hi;
    dif      = hi_c - lo;
    dif_prod = {16'd0, dif} * {17'd0, pos_q[15:0]};
    att_sum  = {1'b0, lo} + {1'b0, dif_prod[32:16]};
    delta_prod   = diff_q * $signed({1'b0, att_q});
    contrib_prod = delta_q * $signed({1'b0, item_q.polar_weight});
    psi_diff = 36'(item_q.angular_flux) - 36'(delta_q);
    psi_ovf  = !((&psi_diff[35:31]) || !(|psi_diff[35:31]));
    psi_sat  = psi_ovf ? (psi_diff[35] ? 32'sh80000000 : 32'sh7FFFFFFF) : psi_diff[31:0];
    sum_full = 45'(rdata_q) + 45'(contrib_q);
    sum_ovf  = !((&sum_full[44:31]) || !(|sum_full[44:31]));
    sum_sat  = sum_ovf ? (sum_full[44] ? 32'sh80000000 : 32'sh7FFFFFFF) : sum_full[31:0];
    addr_lo  = TW'(pos_q[PW-1:16]);
    addr_hi  = TW'(pos_q[PW-1:16]) + 1'b1;
  end

  moc_sfa_atten_rom #(
    .EXP_TABLE_SIZE(EXP_TABLE_SIZE),
    .TW            (TW)
  ) u_rom (
    .clk_i    (clk_i),
    .rd_en_i  (cmd_i.step_rom),
    .addr_lo_i(addr_lo),
    .addr_hi_i(addr_hi),
    .lo_o     (lo),
    .hi_o     (hi)
  );

  always_comb begin
    result = '0;
    case (item_q.req_type)
      REQ_SWEEP: begin
        if (idx_ok && polar_ok) begin
          result.out_angular_flux  = psi_sat_q;
          result.scalar_flux_value = sum_sat_q;
          result.saturated         = sat_psi_q | sat_sum_q;
        end else begin
          result.out_angular_flux = item_q.angular_flux;
        end
      end
      REQ_READ:  if (idx_ok) result.scalar_flux_value = rdata_q;
      REQ_WRITE: if (idx_ok) result.scalar_flux_value = item_q.flux_value;
      default:   result = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_item_i;
    if (cmd_i.step_mul) begin
      prod_q <= {24'd0, item_q.sigma_t} * {24'd0, item_q.seg_length};
      diff_q <= 33'(item_q.angular_flux) - 33'(item_q.reduced_source);
    end
    if (cmd_i.step_tau) begin
      tau_q <= tau_prod[53:16];
      big_q <= tau_prod[53:16] >= TAU_RANGE_Q16;
    end
    if (cmd_i.step_div) q10_q <= q10_prod[Recip10Shift+15:Recip10Shift];
    if (cmd_i.step_pos) begin
      qs_q <= 48'(q10_q) * 48'(EXP_TABLE_SIZE);
      y_q  <= 18'(32'(rem10) * EXP_TABLE_SIZE);
    end
    if (cmd_i.step_addr) pos_q <= pos_full[PW-1:0];
    if (cmd_i.step_interp) att_q <= big_q ? ONE_Q16 : att_sum[16:0];
    if (cmd_i.step_delta) delta_q <= delta_prod[50:16];
    if (cmd_i.step_contrib) begin
      contrib_q <= contrib_prod[59:16];
      psi_sat_q <= psi_sat;
      sat_psi_q <= psi_ovf;
    end
    if (cmd_i.step_update) begin
      sum_sat_q <= sum_sat;
      sat_sum_q <= sum_ovf;
    end
    if (cmd_i.finish) out_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== rtl/moc_segment_flux_attenuation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moc_segment_flux_attenuation
// Segment sweep element with table attenuation and scalar flux store.
// ----------------------------------------------------------------------------
// Items enter on in_valid_i/in_ready_o: a sweep element, a read or a write of
// one (region, group) entry of the scalar flux store. Each item gives one
// result on out_valid_o/out_ready_i. The polar registers are written on the
// cfg channel, which is always ready.
// One item is in work at a time. A sweep runs through the step sequence of
// multiplies, the divide by ten, the table read and the read-modify-write of
// the store entry before the next item is accepted. A read or a write takes
// one store step, an item that changes nothing none.
// After reset all MAX_REGIONS*MAX_GROUPS store entries (4096 by default) are
// cleared, one a cycle, with in_ready_o low; polar registers reset to 1.0.
// A result sits in an output register; the next item is accepted while it
// waits, and the following result waits until out_ready_i takes it.
// ----------------------------------------------------------------------------
module moc_segment_flux_attenuation #(
  parameter int unsigned MAX_REGIONS    = moc_sfa_pkg::DefMaxRegions,
  parameter int unsigned MAX_GROUPS     = moc_sfa_pkg::DefMaxGroups,
  parameter int unsigned MAX_POLAR      = moc_sfa_pkg::DefMaxPolar,
  parameter int unsigned EXP_TABLE_SIZE = moc_sfa_pkg::DefExpTableSize
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  moc_sfa_pkg::in_item_t  in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output moc_sfa_pkg::out_item_t out_item_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [21:0]            cfg_data_i
);
  import moc_sfa_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  moc_sfa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  moc_sfa_datapath #(
    .MAX_REGIONS   (MAX_REGIONS),
    .MAX_GROUPS    (MAX_GROUPS),
    .MAX_POLAR     (MAX_POLAR),
    .EXP_TABLE_SIZE(EXP_TABLE_SIZE)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

// ===== rtl/moc_sfa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moc_sfa_checker
// Port-level checks of the segment flux attenuation block.
// ----------------------------------------------------------------------------
module moc_sfa_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input moc_sfa_pkg::out_item_t out_item_o
);
  import moc_sfa_pkg::*;

  // one item in work: ready drops right after an accept
  a_ready_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("in_ready_o stayed high after an accept");

  // a result is produced only while no item can be accepted
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while idle");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result changed");

endmodule

bind moc_segment_flux_attenuation moc_sfa_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_o (out_item_o)
);

// ===== bench/tb_moc_segment_flux_attenuation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_moc_segment_flux_attenuation
// Self-checking bench: sweep, read and write items against a fixed-point
// predictor of attenuation and scalar flux accumulation, over several
// polar register settings and sender/receiver stall patterns.
// ----------------------------------------------------------------------------
module tb_moc_segment_flux_attenuation;
  import moc_sfa_pkg::*;

  localparam int unsigned TblSize  = 1024;
  localparam int unsigned WdtLimit = 20000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [21:0] cfg_data_i = '0;

  always #1 clk_i = ~clk_i;

  moc_segment_flux_attenuation i_dut (.*);

  // predictor state
  longint unsigned atten_tbl[TblSize+1];
  longint unsigned inv_sin[4];
  logic signed [31:0] flux_store[4096];

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int errors = 0;
  int idle_in_pct = 0, idle_out_pct = 0;
  int quiet_cycles = 0;

  function automatic longint unsigned exp_neg_q32(longint unsigned x);
    longint unsigned whole, f, term, v;
    longint sum;
    whole = x >> 32;
    f = x & 64'hFFFF_FFFF;
    term = 64'd1 << 32;
    sum = longint'(term);
    for (int n = 1; n <= 24; n++) begin
      term = ((term * f) >> 32) / n;
      if (n % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    v = longint'(sum);
    for (longint unsigned k = 0; k < whole && v != 0; k++)
      v = (v * EXP_M1_Q32) >> 32;
    return v;
  endfunction

  function automatic longint unsigned atten_of(longint unsigned tau);
    longint unsigned pos, k, frac, lo, hi;
    if (tau >= 655360) return 65536;
    pos = ((tau * TblSize) << 16) / 655360;
    k = pos >> 16;
    frac = pos & 64'hFFFF;
    if (k >= TblSize) begin
      k = TblSize - 1;
      frac = 64'hFFFF;
    end
    lo = atten_tbl[k];
    hi = atten_tbl[k+1];
    if (hi < lo) hi = lo;
    return lo + (((hi - lo) * frac) >> 16);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic out_item_t sweep_result(in_item_t it);
    out_item_t r;
    longint unsigned tau;
    longint psi, q, att, delta, contrib;
    logic sat;
    int idx;
    r = '0;
    sat = 1'b0;
    idx = int'(it.region) * 16 + int'(it.group);
    case (it.req_type)
      REQ_SWEEP: begin
        psi = longint'(it.angular_flux);
        q = longint'(it.reduced_source);
        tau = ((((64'(it.sigma_t) * 64'(it.seg_length)) >> 16) * inv_sin[it.polar]) >> 16);
        att = longint'(atten_of(tau));
        delta = ((psi - q) * att) >>> 16;
        contrib = (delta * longint'(it.polar_weight)) >>> 16;
        r.out_angular_flux = clamp32(psi - delta, sat);
        r.scalar_flux_value = clamp32(longint'(flux_store[idx]) + contrib, sat);
        flux_store[idx] = r.scalar_flux_value;
        r.saturated = sat;
      end
      REQ_READ: r.scalar_flux_value = flux_store[idx];
      REQ_WRITE: begin
        flux_store[idx] = it.flux_value;
        r.scalar_flux_value = it.flux_value;
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) expected_results.push_back(sweep_result(in_item_i));
      if (!in_valid_i || in_ready_o) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_in_pct) begin
          in_valid_i <= 1'b1;
          in_item_i <= pending_items.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_item_o);
          errors++;
        end else begin
          out_item_t e;
          e = expected_results.pop_front();
          if (e.out_angular_flux !== out_item_o.out_angular_flux) begin
            $display("%0t: out_angular_flux expected %h actual %h", $time,
                     e.out_angular_flux, out_item_o.out_angular_flux);
            errors++;
          end
          if (e.scalar_flux_value !== out_item_o.scalar_flux_value) begin
            $display("%0t: scalar_flux_value expected %h actual %h", $time,
                     e.scalar_flux_value, out_item_o.scalar_flux_value);
            errors++;
          end
          if (e.saturated !== out_item_o.saturated) begin
            $display("%0t: saturated expected %b actual %b", $time,
                     e.saturated, out_item_o.saturated);
            errors++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= idle_out_pct);
    end
  end

  // watchdog on item, result and polar register handshakes
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WdtLimit) begin
      $display("** moc_segment_flux_attenuation: FAILED **");
      $finish;
    end
  end

  task automatic write_polar(input logic [1:0] index, input logic [21:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    inv_sin[index] = 64'(value);
  endtask

  function automatic in_item_t sweep_item(int region_hi);
    in_item_t it;
    it = '0;
    it.req_type = REQ_SWEEP;
    it.region = 8'($urandom_range(region_hi));
    it.group = 4'($urandom_range(15));
    it.polar = 2'($urandom_range(3));
    // mostly moderate fluxes, sometimes full range
    it.angular_flux = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h00FF_FFFF);
    it.reduced_source = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h00FF_FFFF);
    case ($urandom_range(2))
      0: begin
        it.sigma_t = 24'($urandom);
        it.seg_length = 24'($urandom);
      end
      default: begin
        it.sigma_t = 24'($urandom_range(24'h02_FFFF));
        it.seg_length = 24'($urandom_range(24'h03_FFFF));
      end
    endcase
    it.polar_weight = ($urandom_range(3) == 0) ? 24'($urandom) :
                      24'($urandom_range(24'h01_FFFF));
    it.flux_value = $urandom;
    return it;
  endfunction

  task automatic add_random(int count);
    in_item_t it;
    for (int i = 0; i < count; i++) begin
      it = sweep_item(7);
      case ($urandom_range(9))
        0: it.req_type = REQ_READ;
        1: it.req_type = REQ_WRITE;
        2: it.req_type = 2'd3;
        3: it.region = 8'($urandom);
        default: ;
      endcase
      pending_items.push_back(it);
    end
  endtask

  // sample on the falling edge so the driver and monitor have settled
  task automatic drain;
    do @(negedge clk_i);
    while (pending_items.size() != 0 || expected_results.size() != 0 || in_valid_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    in_item_t it;
    for (longint unsigned i = 0; i <= TblSize; i++) begin
      longint unsigned e16;
      e16 = (exp_neg_q32(((i * 655360) << 16) / TblSize) + 64'h8000) >> 16;
      if (e16 > 65536) e16 = 65536;
      atten_tbl[i] = 65536 - e16;
    end
    for (int p = 0; p < 4; p++) inv_sin[p] = 64'(INV_SIN_RESET);
    foreach (flux_store[i]) flux_store[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: polar registers at both extremes and one below 1.0
    write_polar(2'd0, 22'd65536);
    write_polar(2'd1, 22'h3F_FFFF);
    write_polar(2'd2, 22'd1000);
    write_polar(2'd3, 22'd92682);
    it = '0;
    it.req_type = REQ_WRITE; it.region = 8'd255; it.group = 4'd15;
    it.flux_value = 32'sh7FFF_FFF0;
    pending_items.push_back(it);
    it.req_type = REQ_READ;
    pending_items.push_back(it);
    // positive saturation of the store entry
    it.req_type = REQ_SWEEP; it.polar = 2'd1; it.angular_flux = 32'sh7FFF_FFFF;
    it.reduced_source = 32'sh8000_0000; it.sigma_t = 24'hFF_FFFF;
    it.seg_length = 24'hFF_FFFF; it.polar_weight = 24'hFF_FFFF;
    pending_items.push_back(it);
    // zero optical length
    it.region = 8'd0; it.group = 4'd0; it.polar = 2'd0; it.sigma_t = '0;
    it.angular_flux = 32'sh0001_0000; it.reduced_source = 32'sh0000_8000;
    pending_items.push_back(it);
    // negative side, each polar angle
    for (int p = 0; p < 4; p++) begin
      it.polar = 2'(p); it.sigma_t = 24'h01_8000; it.seg_length = 24'h00_C000;
      it.angular_flux = 32'sh8000_0000; it.reduced_source = 32'sh7FFF_FFFF;
      it.polar_weight = 24'h00_4000 << p;
      pending_items.push_back(it);
    end
    it.req_type = REQ_WRITE; it.flux_value = 32'sh8000_0001;
    pending_items.push_back(it);
    it.req_type = REQ_SWEEP;
    pending_items.push_back(it);
    it.req_type = 2'd3;
    pending_items.push_back(it);
    it.req_type = REQ_READ; it.region = 8'd0; it.group = 4'd0;
    pending_items.push_back(it);

    idle_in_pct = 31; idle_out_pct = 50;
    add_random(130);
    drain;
    write_polar(2'd0, 22'h3F_FFFF);
    write_polar(2'd1, 22'd65536);
    write_polar(2'd2, 22'd131072);
    write_polar(2'd3, 22'd75674);
    idle_in_pct = 50; idle_out_pct = 31;
    add_random(130);
    drain;
    write_polar(2'd0, 22'd70000);
    write_polar(2'd1, 22'd300000);
    write_polar(2'd2, 22'h3F_FFFF);
    write_polar(2'd3, 22'd65536);
    idle_in_pct = 0; idle_out_pct = 0;
    add_random(130);
    drain;

    if (errors == 0)
      $display("** moc_segment_flux_attenuation: PASSED **");
    else
      $display("** moc_segment_flux_attenuation: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/moc_sfa_pkg.sv
rtl/moc_sfa_atten_rom.sv
rtl/moc_sfa_ctrl.sv
rtl/moc_sfa_datapath.sv
rtl/moc_segment_flux_attenuation.sv
rtl/moc_sfa_checker.sv
bench/tb_moc_segment_flux_attenuation.sv
